// ----- hdl/atomic_read_modify_write_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Atomic read-modify-write unit: assertion macros
// Concurrent check macros, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ATOMIC_READ_MODIFY_WRITE_UNIT_DEFINES_SVH
`define ATOMIC_READ_MODIFY_WRITE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ARMW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("armw check failed");
`define ARMW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("armw check failed");
`else
`define ARMW_ASSERT_SAME(label, clk, rst, ante, cons)
`define ARMW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/armw_pkg.sv -----
// ----------------------------------------------------------------------------
// Atomic read-modify-write unit: package
// Sizes, operation codes and transaction types shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package armw_pkg;

   localparam int STORE_WORDS      = 1024;
   localparam int STORE_INDEX_BITS = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

   typedef logic [STORE_INDEX_BITS-1:0] store_index_type;

   typedef enum logic [2:0] {
      OP_XCHG_BYTE = 3'd0,
      OP_XCHG_WORD = 3'd1,
      OP_CAS       = 3'd2,
      OP_ADD       = 3'd3,
      OP_SUB       = 3'd4,
      OP_AND       = 3'd5,
      OP_OR        = 3'd6,
      OP_XOR       = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [9:0]  word_address;
      logic [1:0]  byte_lane;
      logic [31:0] operand;
      logic [31:0] expected_value;
   } req_type;

   typedef struct packed {
      logic [31:0] previous_value;
      logic        success;
   } rsp_type;

   typedef struct packed {
      logic            en;
      store_index_type index;
      logic [31:0]     data;
   } ram_write_type;

   typedef struct packed {
      logic        write_en;
      logic [31:0] next_word;
      rsp_type     rsp;
   } alu_result_type;

endpackage

`default_nettype wire

// ----- hdl/armw_ram.sv -----
// ----------------------------------------------------------------------------
// Atomic read-modify-write unit: word store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module armw_ram
   import armw_pkg::*;
(
   input  wire logic            clock,
   input  wire ram_write_type   wr,
   input  wire logic            rd_en,
   input  wire store_index_type rd_index,
   output logic [31:0]          rd_data
);

   logic [31:0] mem [STORE_WORDS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.index] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_index];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/armw_alu.sv -----
// ----------------------------------------------------------------------------
// Atomic read-modify-write unit: modify stage
// Computes the new word, the write enable and the response from the old word.
// ----------------------------------------------------------------------------
`default_nettype none

module armw_alu
   import armw_pkg::*;
(
   input  wire req_type        req,
   input  wire logic [31:0]    old_word,
   output alu_result_type      result
);

   logic [4:0]  shift;
   logic [31:0] mask;
   logic        in_range;

   assign shift    = {req.byte_lane, 3'b000};
   assign mask     = 32'h0000_00FF << shift;
   assign in_range = 32'(req.word_address) < 32'(STORE_WORDS);

   always_comb begin
      result.write_en           = in_range;
      result.next_word          = old_word;
      result.rsp.previous_value = old_word;
      result.rsp.success        = 1'b1;
      case (op_type'(req.req_type))
         OP_XCHG_BYTE: begin
            result.rsp.previous_value = (old_word & mask) >> shift;
            result.next_word = (old_word & ~mask) | ({24'd0, req.operand[7:0]} << shift);
         end
         OP_XCHG_WORD: result.next_word = req.operand;
         OP_CAS: begin
            if (old_word == req.expected_value) begin
               result.next_word = req.operand;
            end else begin
               result.rsp.success = 1'b0;
            end
         end
         OP_ADD:  result.next_word = old_word + req.operand;
         OP_SUB:  result.next_word = old_word - req.operand;
         OP_AND:  result.next_word = old_word & req.operand;
         OP_OR:   result.next_word = old_word | req.operand;
         OP_XOR:  result.next_word = old_word ^ req.operand;
         default: result.next_word = old_word;
      endcase
      if (!in_range) begin
         result.rsp.previous_value = 32'd0;
         result.rsp.success        = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/atomic_read_modify_write_unit.sv -----
// ----------------------------------------------------------------------------
// Atomic read-modify-write unit
// Serialised atomic operations on a word store, one response per request.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_data (req_type)
//   rsp       out         rsp_valid / rsp_stall  rsp_data (rsp_type)
//
// One request per cycle sustained while the response side does not stall; a
// request passes a store read, then modify and write back into the response
// register. Back-to-back requests to the same word take the last written word
// from a forwarding register. After reset the store is cleared one word a
// cycle, req_stall high until the last word is written. A stalled response
// holds the modify stage and then req_stall.
`default_nettype none

`include "atomic_read_modify_write_unit_defines.svh"

module atomic_read_modify_write_unit
   import armw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam store_index_type STORE_LAST = STORE_INDEX_BITS'(STORE_WORDS - 1);

   logic            clr_busy_ff, clr_busy_in;
   store_index_type clr_index_ff, clr_index_in;
   logic            s1_valid_ff, s1_valid_in;
   req_type         s1_req_ff, s1_req_in;
   logic            fwd_valid_ff, fwd_valid_in;
   store_index_type fwd_index_ff, fwd_index_in;
   logic [31:0]     fwd_data_ff, fwd_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            req_accept;
   logic            s1_advance;
   store_index_type s1_index;
   logic [31:0]     ram_rd_data;
   logic [31:0]     old_word;
   ram_write_type   ram_wr;
   alu_result_type  alu_result;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clr_busy_ff || (s1_valid_ff && !s1_advance);
   assign req_accept = req_valid && !req_stall;
   assign s1_index   = STORE_INDEX_BITS'(s1_req_ff.word_address);
   assign old_word   = (fwd_valid_ff && fwd_index_ff == s1_index) ? fwd_data_ff : ram_rd_data;

   armw_ram u_ram (
      .clock    (clock),
      .wr       (ram_wr),
      .rd_en    (req_accept),
      .rd_index (STORE_INDEX_BITS'(req_data.word_address)),
      .rd_data  (ram_rd_data)
   );

   armw_alu u_alu (
      .req      (s1_req_ff),
      .old_word (old_word),
      .result   (alu_result)
   );

   always_comb begin
      if (clr_busy_ff) begin
         ram_wr.en    = 1'b1;
         ram_wr.index = clr_index_ff;
         ram_wr.data  = 32'd0;
      end else begin
         ram_wr.en    = s1_advance && alu_result.write_en;
         ram_wr.index = s1_index;
         ram_wr.data  = alu_result.next_word;
      end
   end

   always_comb begin
      clr_busy_in  = clr_busy_ff;
      clr_index_in = clr_index_ff;
      if (clr_busy_ff) begin
         clr_index_in = clr_index_ff + store_index_type'(1);
         if (clr_index_ff == STORE_LAST) begin
            clr_busy_in = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_req_in   = req_data;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      fwd_valid_in = fwd_valid_ff;
      fwd_index_in = fwd_index_ff;
      fwd_data_in  = fwd_data_ff;
      if (!clr_busy_ff && ram_wr.en) begin
         fwd_valid_in = 1'b1;
         fwd_index_in = s1_index;
         fwd_data_in  = alu_result.next_word;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = alu_result.rsp;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_index_ff <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_index_ff <= clr_index_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff    <= s1_req_in;
      fwd_index_ff <= fwd_index_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ARMW_ASSERT_SAME(a_clear_empty, clock, reset, clr_busy_ff, !s1_valid_ff && !rsp_valid_ff)
   `ARMW_ASSERT_NEXT(a_accept_fills, clock, reset, req_accept, s1_valid_ff)
   `ARMW_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_advance,
                     s1_valid_ff && $stable(s1_req_ff))
   `ARMW_ASSERT_NEXT(a_fwd_tracks, clock, reset, !clr_busy_ff && ram_wr.en,
                     fwd_valid_ff && fwd_data_ff == $past(alu_result.next_word))

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Atomic read-modify-write unit: testbench
// Queued requests are driven through the valid/stall channel and every
// response is checked against an in-bench model of the word store. Traffic
// covers all eight operations, compare-and-swap hits and misses, every byte
// lane, wrap-around and back-to-back transactions on a few hot words. Both
// sides idle at random, and one long response hold fills the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
   import armw_pkg::*;
;

   localparam int unsigned TIMEOUT_CYCLES = 200000;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned RANDOM_BATCH   = 410;

   typedef struct packed {
      logic [31:0] next_word;
      rsp_type     rsp;
   } word_update_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type     pending_requests [$];
   rsp_type     expected_results [$];
   logic [31:0] plan_words   [STORE_WORDS];
   logic [31:0] stored_words [STORE_WORDS];
   logic [9:0]  last_address = '0;

   int unsigned send_idle_pct = 10;
   int unsigned recv_idle_pct = 56;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;
   int unsigned failure_count = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count  = 0;
   int unsigned cas_miss_count = 0;
   bit          req_taken = 1'b0;

   atomic_read_modify_write_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic word_update_type atomic_update(logic [31:0] old, req_type r);
      word_update_type u;
      logic [4:0]      shift;
      u.next_word          = old;
      u.rsp.previous_value = old;
      u.rsp.success        = 1'b1;
      shift                = {r.byte_lane, 3'b000};
      case (op_type'(r.req_type))
         OP_XCHG_BYTE: begin
            u.rsp.previous_value = (old >> shift) & 32'h0000_00FF;
            u.next_word = (old & ~(32'h0000_00FF << shift))
                        | ({24'h0, r.operand[7:0]} << shift);
         end
         OP_XCHG_WORD: u.next_word = r.operand;
         OP_CAS: begin
            if (old == r.expected_value) begin
               u.next_word = r.operand;
            end else begin
               u.rsp.success = 1'b0;
            end
         end
         OP_ADD: u.next_word = old + r.operand;
         OP_SUB: u.next_word = old - r.operand;
         OP_AND: u.next_word = old & r.operand;
         OP_OR:  u.next_word = old | r.operand;
         OP_XOR: u.next_word = old ^ r.operand;
         default: u.next_word = old;
      endcase
      return u;
   endfunction

   task automatic queue_request(op_type op, logic [9:0] addr, logic [1:0] lane,
                                logic [31:0] value, logic [31:0] compare);
      req_type         r;
      word_update_type upd;
      r.req_type       = op;
      r.word_address   = addr;
      r.byte_lane      = lane;
      r.operand        = value;
      r.expected_value = compare;
      if (int'(addr) < STORE_WORDS) begin
         upd              = atomic_update(plan_words[addr], r);
         plan_words[addr] = upd.next_word;
      end
      last_address = addr;
      pending_requests.push_back(r);
   endtask

   task automatic add_random_requests(int unsigned count);
      op_type      op;
      logic [9:0]  addr;
      logic [31:0] value;
      logic [31:0] compare;
      int unsigned pick;
      repeat (count) begin
         op   = op_type'($urandom_range(7));
         pick = $urandom_range(99);
         if (pick < 50) begin
            case ($urandom_range(3))
               0:       addr = 10'd0;
               1:       addr = 10'd1;
               2:       addr = 10'd1023;
               default: addr = 10'd682;
            endcase
         end else if (pick < 65) begin
            addr = last_address;
         end else begin
            addr = 10'($urandom_range(1023));
         end
         case ($urandom_range(7))
            0:       value = 32'h0;
            1:       value = 32'hFFFF_FFFF;
            2, 3:    value = 32'($urandom_range(255));
            default: value = $urandom();
         endcase
         pick = $urandom_range(99);
         if (pick < 60) begin
            compare = plan_words[addr];
         end else if (pick < 80) begin
            compare = plan_words[addr] ^ (32'h1 << $urandom_range(31));
         end else begin
            compare = $urandom();
         end
         queue_request(op, addr, 2'($urandom_range(3)), value, compare);
      end
   endtask

   task automatic wait_until_idle();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // offer queued requests; hold the payload while stalled
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : transaction_check
      rsp_type         want;
      word_update_type upd;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding: previous_value %08h",
                      rsp_data.previous_value);
               failure_count++;
            end else begin
               want = expected_results.pop_front();
               checked_count++;
               if (rsp_data.previous_value !== want.previous_value) begin
                  $error("previous_value: expected %08h, actual %08h",
                         want.previous_value, rsp_data.previous_value);
                  failure_count++;
               end
               if (rsp_data.success !== want.success) begin
                  $error("success: expected %0b, actual %0b",
                         want.success, rsp_data.success);
                  failure_count++;
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            accepted_count++;
            if (int'(req_data.word_address) < STORE_WORDS) begin
               upd = atomic_update(stored_words[req_data.word_address], req_data);
               stored_words[req_data.word_address] = upd.next_word;
               expected_results.push_back(upd.rsp);
               if (!upd.rsp.success) begin
                  cas_miss_count++;
               end
            end else begin
               expected_results.push_back('0);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < STORE_WORDS; i++) begin
         plan_words[i]   = '0;
         stored_words[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, every operation, byte lanes, compare-and-swap hit and miss
      queue_request(OP_XCHG_WORD, 10'd0, 2'($urandom_range(3)), 32'hFFFF_FFFF, $urandom());
      queue_request(OP_XCHG_BYTE, 10'd0, 2'd0, 32'h1234_5600, $urandom());
      queue_request(OP_XCHG_BYTE, 10'd0, 2'd1, 32'hFFFF_FFA5, $urandom());
      queue_request(OP_XCHG_BYTE, 10'd0, 2'd2, 32'h0000_005A, $urandom());
      queue_request(OP_XCHG_BYTE, 10'd0, 2'd3, 32'h0000_0000, $urandom());
      queue_request(OP_XCHG_WORD, 10'd0, 2'($urandom_range(3)), 32'h0000_0000, $urandom());
      queue_request(OP_XCHG_WORD, 10'd0, 2'd3, 32'h8765_4321, 32'hFFFF_FFFF);
      queue_request(OP_CAS, 10'd0, 2'($urandom_range(3)), 32'hCAFE_F00D,
                    plan_words[0] ^ 32'h8000_0000);
      queue_request(OP_CAS, 10'd0, 2'($urandom_range(3)), 32'hCAFE_F00D, plan_words[0]);
      queue_request(OP_CAS, 10'd1023, 2'($urandom_range(3)), 32'hFFFF_FFFF, 32'h0);
      queue_request(OP_CAS, 10'd1023, 2'($urandom_range(3)), 32'h0, 32'h0);
      queue_request(OP_ADD, 10'd1023, 2'($urandom_range(3)), 32'h1, $urandom());
      queue_request(OP_ADD, 10'd1023, 2'($urandom_range(3)), 32'hFFFF_FFFF, $urandom());
      queue_request(OP_SUB, 10'd1023, 2'($urandom_range(3)), 32'hFFFF_FFFF, $urandom());
      queue_request(OP_SUB, 10'd1023, 2'($urandom_range(3)), 32'h1, $urandom());
      queue_request(OP_AND, 10'd1023, 2'($urandom_range(3)), 32'h0F0F_0F0F, $urandom());
      queue_request(OP_OR, 10'd1023, 2'($urandom_range(3)), 32'hF0F0_0000, $urandom());
      queue_request(OP_XOR, 10'd1023, 2'($urandom_range(3)), 32'hFFFF_FFFF, $urandom());
      queue_request(OP_AND, 10'd1023, 2'($urandom_range(3)), 32'h0, $urandom());
      queue_request(OP_OR, 10'd512, 2'($urandom_range(3)), 32'hFFFF_FFFF, $urandom());
      queue_request(OP_XOR, 10'd512, 2'($urandom_range(3)), 32'hAAAA_5555, $urandom());
      queue_request(OP_XCHG_BYTE, 10'd512, 2'd3, 32'h0000_0011, $urandom());
      wait_until_idle();

      add_random_requests(RANDOM_BATCH);
      wait_until_idle();

      send_idle_pct = 56;
      recv_idle_pct = 10;
      add_random_requests(RANDOM_BATCH);
      wait_until_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = hold_requests + 1;
      add_random_requests(RANDOM_BATCH);
      wait_until_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d responses never arrived", expected_results.size());
         failure_count++;
      end

      $display("Covered %0d requests, %0d responses checked, %0d compare-and-swap misses,",
               accepted_count, checked_count, cas_miss_count);
      $display("all eight operations under sender, receiver and no idling plus a long hold.");
      if (failure_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
